FILE: rtl/cda_pkg.sv
// Types, codes and the month-length table for the calendar date adder.
// No dependencies; every other file in rtl imports this package.
`default_nettype none

package cda_pkg;

  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned COUNT_W = 12;
  localparam int unsigned STEPS_W = 15;

  localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

  localparam logic [2:0] ACT_DAYS    = 3'd0;
  localparam logic [2:0] ACT_WEEKS   = 3'd1;
  localparam logic [2:0] ACT_MONTHS  = 3'd2;
  localparam logic [2:0] ACT_YEARS   = 3'd3;
  localparam logic [2:0] ACT_DECADES = 3'd4;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_SAT = 2'd1;
  localparam logic [1:0] ST_BAD = 2'd2;

  localparam logic [MONTH_W-1:0] MON_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MON_DEC = 4'd12;
  localparam logic [MONTH_W-1:0] MON_JAN = 4'd1;

  typedef struct packed {
    logic [2:0]         action;
    logic [COUNT_W-1:0] count;
    logic [DAY_W-1:0]   day_in;
    logic [MONTH_W-1:0] month_in;
    logic [YEAR_W-1:0]  year_in;
  } in_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day_out;
    logic [MONTH_W-1:0] month_out;
    logic [YEAR_W-1:0]  year_out;
    logic [1:0]         status;
  } out_t;

  typedef struct packed {
    logic load;
    logic quo;
    logic leap;
    logic check;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic iter;
    logic n_zero;
    logic wrap;
    logic sat;
  } sts_t;

  function automatic logic [DAY_W-1:0] cda_days(input logic leap,
                                                 input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      MON_FEB:                                    len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/calendar_date_adder.sv
// Calendar date adder: one date transaction at a time. After accept, the
// controller runs the quotient, leap-year and check states. Years, decades,
// invalid or unknown actions then finish; day, week or month actions enter
// the step loop of single-unit steps until the count is spent or the year
// saturates, running the quotient and leap-year states again at each year
// boundary crossed. Busy holds off new work until the result is shown.
// Synchronous active-low reset returns the controller to idle; no other state.
`default_nettype none

module calendar_date_adder (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire cda_pkg::in_t in_item,
  output logic              out_valid,
  output cda_pkg::out_t     out_item
);
  import cda_pkg::*;

  cmd_t cmd;
  sts_t sts;

  cda_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  cda_dp u_dp (
    .clk      (clk),
    .in_item  (in_item),
    .cmd      (cmd),
    .sts      (sts),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

FILE: rtl/cda_dp.sv
// Datapath of the calendar date adder: date registers, step counter,
// leap-year unit and step logic. Depends on cda_pkg.
`default_nettype none

module cda_dp (
  input  wire logic          clk,
  input  wire cda_pkg::in_t  in_item,
  input  wire cda_pkg::cmd_t cmd,
  output cda_pkg::sts_t      sts,
  output cda_pkg::out_t      out_item
);
  import cda_pkg::*;

  logic [DAY_W-1:0]   d_r, d_nxt;
  logic [MONTH_W-1:0] m_r, m_nxt;
  logic [YEAR_W-1:0]  y_r, y_nxt;
  logic [2:0]         act_r, act_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [STEPS_W-1:0] n_r, n_nxt;
  logic [1:0]         st_r, st_nxt;
  logic [7:0]         q_r, q_nxt;
  logic               leap_r, leap_nxt;

  logic [26:0]        prod;
  logic [YEAR_W-1:0]  hund;
  logic [YEAR_W-1:0]  rem;
  logic [DAY_W-1:0]   len_cur;
  logic [DAY_W-1:0]   len_next;
  logic [MONTH_W-1:0] m_inc;
  logic               day_mode;
  logic               mon_mode;
  logic               year_mode;
  logic [YEAR_W+1:0]  sum;
  logic [YEAR_W+1:0]  add;

  always_comb begin
    prod     = 27'(y_r) * 27'd5243;
    hund     = YEAR_W'({q_r, 6'd0}) + YEAR_W'({q_r, 5'd0}) + YEAR_W'({q_r, 2'd0});
    rem      = y_r - hund;
    len_cur  = cda_days(leap_r, m_r);
    m_inc    = m_r + 4'd1;
    len_next = (m_r == MON_DEC) ? 5'd31 : cda_days(leap_r, m_inc);
    day_mode  = (act_r == ACT_DAYS) || (act_r == ACT_WEEKS);
    mon_mode  = (act_r == ACT_MONTHS);
    year_mode = (act_r == ACT_YEARS) || (act_r == ACT_DECADES);
    if (act_r == ACT_DECADES) begin
      add = (YEAR_W+2)'({cnt_r, 3'd0}) + (YEAR_W+2)'({cnt_r, 1'd0});
    end else begin
      add = (YEAR_W+2)'(cnt_r);
    end
    sum = (YEAR_W+2)'(y_r) + add;

    sts.bad    = (y_r > YEAR_MAX) || (m_r == 4'd0) || (m_r > MON_DEC) ||
                 (d_r == 5'd0) || (d_r > len_cur);
    sts.iter   = day_mode || mon_mode;
    sts.n_zero = (n_r == '0);
    sts.wrap   = (m_r == MON_DEC) && (mon_mode || (d_r == len_cur));
    sts.sat    = sts.wrap && (y_r >= YEAR_MAX);
  end

  always_comb begin
    d_nxt    = d_r;
    m_nxt    = m_r;
    y_nxt    = y_r;
    act_nxt  = act_r;
    cnt_nxt  = cnt_r;
    n_nxt    = n_r;
    st_nxt   = st_r;
    q_nxt    = q_r;
    leap_nxt = leap_r;
    if (cmd.load) begin
      d_nxt   = in_item.day_in;
      m_nxt   = in_item.month_in;
      y_nxt   = in_item.year_in;
      act_nxt = in_item.action;
      cnt_nxt = in_item.count;
      st_nxt  = ST_OK;
    end
    if (cmd.quo) begin
      q_nxt = prod[26:19];
    end
    if (cmd.leap) begin
      leap_nxt = (y_r[1:0] == 2'd0) && ((rem != '0) || (q_r[1:0] == 2'd0));
    end
    if (cmd.check) begin
      if (sts.bad) begin
        st_nxt = ST_BAD;
      end else if (act_r == ACT_WEEKS) begin
        n_nxt = STEPS_W'({cnt_r, 3'd0}) - STEPS_W'(cnt_r);
      end else if (sts.iter) begin
        n_nxt = STEPS_W'(cnt_r);
      end else if (year_mode) begin
        if (sum > (YEAR_W+2)'(YEAR_MAX)) begin
          y_nxt  = YEAR_MAX;
          st_nxt = ST_SAT;
        end else begin
          y_nxt = sum[YEAR_W-1:0];
        end
      end
    end
    if (cmd.step) begin
      n_nxt = n_r - STEPS_W'(1);
      if (sts.sat) begin
        st_nxt = ST_SAT;
        if (day_mode) begin
          d_nxt = 5'd31;
        end
      end else if (day_mode) begin
        if (d_r == len_cur) begin
          d_nxt = 5'd1;
          if (m_r == MON_DEC) begin
            m_nxt = MON_JAN;
            y_nxt = y_r + 14'd1;
          end else begin
            m_nxt = m_inc;
          end
        end else begin
          d_nxt = d_r + 5'd1;
        end
      end else begin
        if (m_r == MON_DEC) begin
          m_nxt = MON_JAN;
          y_nxt = y_r + 14'd1;
        end else begin
          m_nxt = m_inc;
        end
        if (d_r > len_next) begin
          d_nxt = len_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    d_r    <= d_nxt;
    m_r    <= m_nxt;
    y_r    <= y_nxt;
    act_r  <= act_nxt;
    cnt_r  <= cnt_nxt;
    n_r    <= n_nxt;
    st_r   <= st_nxt;
    q_r    <= q_nxt;
    leap_r <= leap_nxt;
  end

  assign out_item.day_out   = d_r;
  assign out_item.month_out = m_r;
  assign out_item.year_out  = y_r;
  assign out_item.status    = st_r;

endmodule

`default_nettype wire

FILE: rtl/cda_ctrl.sv
// Controller of the calendar date adder: sequences load, leap-year update,
// validation and per-unit steps. Depends on cda_pkg.
`default_nettype none

module cda_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire cda_pkg::sts_t sts,
  output cda_pkg::cmd_t      cmd,
  output logic               busy,
  output logic               out_valid
);
  import cda_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_QUO   = 6'b000010,
    S_LEAP  = 6'b000100,
    S_CHECK = 6'b001000,
    S_STEP  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   first_r, first_nxt;

  always_comb begin
    state_nxt = state_r;
    first_nxt = first_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          first_nxt = 1'b1;
          state_nxt = S_QUO;
        end
      end
      S_QUO: begin
        cmd.quo   = 1'b1;
        state_nxt = S_LEAP;
      end
      S_LEAP: begin
        cmd.leap  = 1'b1;
        state_nxt = first_r ? S_CHECK : S_STEP;
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        first_nxt = 1'b0;
        state_nxt = (!sts.bad && sts.iter) ? S_STEP : S_DONE;
      end
      S_STEP: begin
        if (sts.n_zero) begin
          state_nxt = S_DONE;
        end else begin
          cmd.step = 1'b1;
          if (sts.sat) begin
            state_nxt = S_DONE;
          end else if (sts.wrap) begin
            state_nxt = S_QUO;
          end
        end
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

`default_nettype wire
